### src/nns12d_pkg.sv
// Package for the 12-dimensional nearest neighbor search block.
// Holds sizes, field widths and register indexes; no dependencies.
package nns12d_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int DIMENSIONS  = 12;
	localparam int COORD_WIDTH = 16;

	localparam int IDX_W   = $clog2(MAX_POINTS);
	localparam int ROW_W   = DIMENSIONS * COORD_WIDTH;
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int SQ_W    = 2 * COORD_WIDTH;
	localparam int GROUP   = 3;
	localparam int NGROUPS = (DIMENSIONS + GROUP - 1) / GROUP;
	localparam int PART_W  = SQ_W + 2;
	localparam int DIST_W  = 36;
	localparam int OUT_IDX_W = 10;

	localparam int REFCNT_W = 11;
	localparam int QCNT_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [REFCNT_W-1:0] REFCNT_MAX   = REFCNT_W'(MAX_POINTS);
	localparam logic [REFCNT_W-1:0] REFCNT_RESET = REFCNT_W'(1024);
	localparam logic [QCNT_W-1:0]   QCNT_RESET   = QCNT_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFERENCE_COUNT = 2'd0,
		REG_QUERY_COUNT     = 2'd1
	} reg_index_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

endpackage

### src/nearest_neighbor_search_12d.sv
// Top level of the brute-force 12-dimensional nearest neighbor search.
// Uses nns12d_pkg for sizes and register indexes; holds the point memory.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | coord_0 .. coord_11 (signed Q8.8)
//  out     | out_valid / out_ready  | nearest_index, nearest_distance
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Reference point words may arrive back to back. During a query one memory
// row (one point) is read per cycle, followed by the square, partial sum and
// compare stages. The result sits in an output register, so the next word is
// taken while it waits; a query finishing while the register is still full
// stalls until it drains. Reset is asynchronous and clears all control state;
// the point memory is not cleared. cfg_ready is always high.
module nearest_neighbor_search_12d (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_0,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_1,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_2,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_3,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_4,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_5,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_6,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_7,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_8,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_9,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_10,
	input  logic signed [nns12d_pkg::COORD_WIDTH-1:0] coord_11,
	output logic out_valid,
	input  logic out_ready,
	output logic [nns12d_pkg::OUT_IDX_W-1:0] nearest_index,
	output logic [nns12d_pkg::DIST_W-1:0] nearest_distance,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [nns12d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nns12d_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	localparam int IDX_W   = nns12d_pkg::IDX_W;
	localparam int ROW_W   = nns12d_pkg::ROW_W;
	localparam int CW      = nns12d_pkg::COORD_WIDTH;
	localparam int DIMS    = nns12d_pkg::DIMENSIONS;
	localparam int DIFF_W  = nns12d_pkg::DIFF_W;
	localparam int SQ_W    = nns12d_pkg::SQ_W;
	localparam int PART_W  = nns12d_pkg::PART_W;
	localparam int DIST_W  = nns12d_pkg::DIST_W;
	localparam int NGROUPS = nns12d_pkg::NGROUPS;
	localparam int GROUP   = nns12d_pkg::GROUP;
	localparam int RC_W    = nns12d_pkg::REFCNT_W;
	localparam int QC_W    = nns12d_pkg::QCNT_W;

	// configuration
	logic [RC_W-1:0] ref_count_q;
	logic [QC_W-1:0] query_count_q;
	logic [RC_W-1:0] eff_ref;
	logic [QC_W-1:0] eff_query;

	// control
	state_t          state_q;
	logic            phase_q;
	logic [IDX_W-1:0] load_cnt_q;
	logic [QC_W-1:0] query_cnt_q;
	logic [IDX_W-1:0] k_q;
	logic            in_fire;
	logic            scan_last;
	logic            load_end;
	logic            query_end;

	// query held for the scan
	logic [ROW_W-1:0] query_q;
	logic [ROW_W-1:0] in_row;

	// point memory, one row per point
	logic [ROW_W-1:0] mem [nns12d_pkg::MAX_POINTS];
	logic             mem_we;

	// pipeline
	logic             valid_s1, valid_s2, valid_s3;
	logic             last_s1, last_s2, last_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [ROW_W-1:0] row_s1;
	logic [SQ_W-1:0]  sq_d   [DIMS];
	logic [SQ_W-1:0]  sq_s2  [DIMS];
	logic [PART_W-1:0] part_d  [NGROUPS];
	logic [PART_W-1:0] part_s3 [NGROUPS];
	logic [DIST_W-1:0] sum_d;
	logic              better;

	// running best and result
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              done_q;
	logic              out_valid_q;
	logic              out_load;
	logic [DIST_W-1:0] out_dist_q;
	logic [IDX_W-1:0]  out_idx_q;

	assign in_row = {coord_11, coord_10, coord_9, coord_8, coord_7, coord_6,
		coord_5, coord_4, coord_3, coord_2, coord_1, coord_0};

	// zero counts act as one; reference count clamps to the memory size
	always_comb begin
		eff_ref = ref_count_q;
		if (ref_count_q == '0) begin
			eff_ref = RC_W'(1);
		end else if (ref_count_q > nns12d_pkg::REFCNT_MAX) begin
			eff_ref = nns12d_pkg::REFCNT_MAX;
		end
		eff_query = (query_count_q == '0) ? QC_W'(1) : query_count_q;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign mem_we    = in_fire && !phase_q;
	assign load_end  = (RC_W'(load_cnt_q) + RC_W'(1)) >= eff_ref;
	assign query_end = ({1'b0, query_cnt_q} + (QC_W+1)'(1)) >= {1'b0, eff_query};
	assign scan_last = (RC_W'(k_q) + RC_W'(1)) >= eff_ref;
	assign out_load  = (state_q == ST_FLUSH) && done_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q   <= nns12d_pkg::REFCNT_RESET;
			query_count_q <= nns12d_pkg::QCNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == nns12d_pkg::REG_REFERENCE_COUNT) begin
				ref_count_q <= cfg_data[RC_W-1:0];
			end else if (cfg_index == nns12d_pkg::REG_QUERY_COUNT) begin
				query_count_q <= cfg_data[QC_W-1:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			load_cnt_q  <= '0;
			query_cnt_q <= '0;
			k_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (!phase_q) begin
							if (load_end) begin
								load_cnt_q  <= '0;
								query_cnt_q <= '0;
								phase_q     <= 1'b1;
							end else begin
								load_cnt_q <= load_cnt_q + IDX_W'(1);
							end
						end else begin
							if (query_end) begin
								query_cnt_q <= '0;
								load_cnt_q  <= '0;
								phase_q     <= 1'b0;
							end else begin
								query_cnt_q <= query_cnt_q + QC_W'(1);
							end
							k_q     <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					k_q <= k_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// memory: write while loading, read one row per scan cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_cnt_q] <= in_row;
		end
		row_s1 <= mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (in_fire && phase_q) begin
			query_q <= in_row;
		end
	end

	// per-lane difference and square
	always_comb begin
		logic signed [DIFF_W-1:0]   r, q, diff;
		logic signed [2*DIFF_W-1:0] prod;
		for (int d = 0; d < DIMS; d++) begin
			r    = DIFF_W'(signed'(row_s1[d*CW +: CW]));
			q    = DIFF_W'(signed'(query_q[d*CW +: CW]));
			diff = r - q;
			prod = diff * diff;
			sq_d[d] = prod[SQ_W-1:0];
		end
	end

	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			part_d[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < DIMS) begin
					part_d[g] = part_d[g] + PART_W'(sq_s2[g * GROUP + j]);
				end
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			sum_d = sum_d + DIST_W'(part_s3[g]);
		end
		// the first point sets the best; after it only a strictly smaller distance replaces the best
		better = (idx_s3 == '0) || (sum_d < best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= k_q;
		last_s1 <= scan_last;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		sq_s2   <= sq_d;
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		part_s3 <= part_d;
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && better) begin
			best_q     <= sum_d;
			best_idx_q <= idx_s3;
		end
		if (out_load) begin
			out_dist_q <= best_q;
			out_idx_q  <= best_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s3 && last_s3) begin
				done_q <= 1'b1;
			end else if (out_load) begin
				done_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign nearest_distance = out_dist_q;
	assign nearest_index    = nns12d_pkg::OUT_IDX_W'(out_idx_q);

`ifndef ASSERT_OFF
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !valid_s1 && !valid_s2 && !valid_s3 && !done_q)
		else $error("new word taken while a scan is still in flight");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE) && !valid_s1)
		else $error("memory written during a scan");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && last_s3 |=> done_q && (state_q == ST_FLUSH))
		else $error("last compare did not mark the result done");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done_q))
		else $error("result shown without a finished scan");
`endif

endmodule
